// ===== hw/rtl/ura_pkg.sv =====
// Shared types, widths and constants for the ultrasonic range averager.
package ura_pkg;

    // Field and state widths
    localparam int TICK_W     = 16;
    localparam int COUNT_W    = 8;
    localparam int SUM_W      = 18;
    localparam int DIST_W     = 10;
    localparam int RAW_DIST_W = 11;  // width*343/20000 peaks at 1123
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Divider for the mean: distance sum over valid round count
    localparam int DIVIDEND_W = SUM_W;
    localparam int DIVISOR_W  = COUNT_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // cm = ticks * 343 / 20000 as (ticks * CM_RECIP) >> CM_SHIFT,
    // CM_RECIP = ceil(343 * 2^30 / 20000); exact for every 16-bit width
    localparam int CM_RECIP_W = 25;
    localparam int CM_SHIFT   = 30;
    localparam int CM_PROD_W  = TICK_W + CM_RECIP_W;

    typedef logic [TICK_W-1:0]     tick_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [DIST_W-1:0]     dist_t;
    typedef logic [RAW_DIST_W-1:0] raw_dist_t;
    typedef logic [DIVIDEND_W-1:0] dividend_t;
    typedef logic [DIVISOR_W-1:0]  divisor_t;
    typedef logic [DIV_CNT_W-1:0]  div_cnt_t;

    // Trigger pulse shape in ticks
    localparam tick_t PRE_LOW_TICKS = 16'd2;
    localparam tick_t HIGH_TICKS    = 16'd10;

    localparam logic [CM_RECIP_W-1:0] CM_RECIP = 25'd18414673;

    // Register reset values
    localparam count_t SAMPLE_COUNT_RST = 8'd4;
    localparam tick_t  TIMEOUT_RST      = 16'd60000;
    localparam tick_t  GAP_RST          = 16'd60000;
    localparam dist_t  MAX_DIST_RST     = 10'd400;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT = 2'd0,
        REG_TIMEOUT      = 2'd1,
        REG_GAP          = 2'd2,
        REG_MAX_DIST     = 2'd3
    } cfg_idx_t;

endpackage

// ===== hw/rtl/ura_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ura_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  ura_pkg::dividend_t   dividend,
    input  ura_pkg::divisor_t    divisor,
    output logic                 done,
    output ura_pkg::dividend_t   quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    ura_pkg::div_cnt_t   cnt_reg, cnt_next;
    ura_pkg::dividend_t  work_reg, work_next;
    ura_pkg::divisor_t   rem_reg, rem_next;
    ura_pkg::divisor_t   dsr_reg, dsr_next;

    logic [ura_pkg::DIVISOR_W:0] rem_shift;
    logic [ura_pkg::DIVISOR_W:0] rem_diff;
    logic                        fits;

    assign rem_shift = {rem_reg, work_reg[ura_pkg::DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = ura_pkg::div_cnt_t'(ura_pkg::DIVIDEND_W);
            work_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next  = fits ? rem_diff[ura_pkg::DIVISOR_W-1:0]
                             : rem_shift[ura_pkg::DIVISOR_W-1:0];
            work_next = {work_reg[ura_pkg::DIVIDEND_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == ura_pkg::div_cnt_t'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

// ===== hw/rtl/ultrasonic_range_averager.sv =====
// Top level of the ultrasonic range averager: tick sequencer, registers, result beat.
//
// One input beat is one 1 us tick carrying the sampled echo level and a start
// request; every input beat yields exactly one result beat carrying the trigger
// level, busy, done, the averaged distance and the no-valid flag. A start while
// idle runs sample_count ranging rounds (trigger low 2 ticks, high 10 ticks, wait
// for echo rise, count the echo width, both waits bounded by timeout_ticks, then
// gap_ticks idle ticks). The width converts to cm as width*343/20000, truncated,
// by a reciprocal multiply; distances below the distance limit are summed and
// counted, and the last round reports their truncated mean or no_valid. Ticks are
// processed one at a time and the block is not ready meanwhile: an ordinary tick
// passes through accept, then load of the result register; the tick where the
// echo falls goes through accept, multiply, range check and load, with round
// bookkeeping before the load when a zero gap also closes the round; a tick that
// closes the measurement with valid rounds runs the mean on the 18-step bit-serial
// divider. A stalled result channel delays the load. The result register lets the
// next tick be accepted while a result waits to be taken. Configuration is a plain
// write port (cfg_we, cfg_idx, cfg_wdata) and is to be written only while no tick
// is in flight.
module ultrasonic_range_averager (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tick input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_start_req,
    input  logic                              s_echo_level,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_trigger_level,
    output logic                              m_busy_res,
    output logic                              m_done_res,
    output logic [ura_pkg::DIST_W-1:0]        m_range_cm,
    output logic                              m_no_valid,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [ura_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [ura_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // ranging phase, advanced once per tick
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE_LOW,
        PH_HIGH,
        PH_WAIT_RISE,
        PH_MEASURE,
        PH_GAP
    } phase_t;

    // per-tick sequencer
    typedef enum logic [2:0] {
        ST_IN,      // waiting for a tick
        ST_MUL,     // width times reciprocal into the cm register
        ST_DDIST,   // range check and sum
        ST_FIN,     // round bookkeeping
        ST_DAVG,    // waiting for the mean
        ST_OUT      // hand the result to the output register
    } seq_t;

    // configuration registers
    ura_pkg::count_t  sample_count_reg;
    ura_pkg::tick_t   timeout_reg;
    ura_pkg::tick_t   gap_reg;
    ura_pkg::dist_t   max_dist_reg;

    // ranging state
    seq_t             st_reg, st_next;
    phase_t           phase_reg, phase_next;
    ura_pkg::tick_t   tick_reg, tick_next;
    ura_pkg::tick_t   width_reg, width_next;
    ura_pkg::count_t  round_reg, round_next;
    ura_pkg::sum_t    sum_reg, sum_next;
    ura_pkg::count_t  valid_cnt_reg, valid_cnt_next;
    ura_pkg::raw_dist_t cm_reg, cm_next;

    // pending result of the tick in flight
    logic             res_trig_reg, res_trig_next;
    logic             res_done_reg, res_done_next;
    ura_pkg::dist_t   res_dist_reg, res_dist_next;
    logic             res_none_reg, res_none_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             m_trig_reg, m_trig_next;
    logic             m_busy_reg, m_busy_next;
    logic             m_done_reg, m_done_next;
    ura_pkg::dist_t   m_dist_reg, m_dist_next;
    logic             m_none_reg, m_none_next;

    // mean divider
    logic                 div_start;
    logic                 div_done;
    ura_pkg::dividend_t   div_dividend;
    ura_pkg::divisor_t    div_divisor;
    ura_pkg::dividend_t   div_quot;

    logic                 accept;
    logic                 round_end;
    logic                 out_free;
    ura_pkg::tick_t       tick_inc;
    ura_pkg::count_t      round_inc;
    logic [ura_pkg::CM_PROD_W-1:0] cm_prod;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (st_reg == ST_IN);
    assign out_free  = !m_valid_reg || m_ready;
    assign tick_inc  = tick_reg + 1'b1;
    assign round_inc = round_reg + 1'b1;
    assign cm_prod   = width_reg * ura_pkg::CM_RECIP;

    // the divider only ever computes the mean
    assign div_dividend = sum_reg;
    assign div_divisor  = valid_cnt_reg;

    ura_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // configuration writes take effect at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= ura_pkg::SAMPLE_COUNT_RST;
            timeout_reg      <= ura_pkg::TIMEOUT_RST;
            gap_reg          <= ura_pkg::GAP_RST;
            max_dist_reg     <= ura_pkg::MAX_DIST_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                ura_pkg::REG_SAMPLE_COUNT: begin
                    sample_count_reg <= cfg_wdata[ura_pkg::COUNT_W-1:0];
                end
                ura_pkg::REG_TIMEOUT: begin
                    timeout_reg <= cfg_wdata[ura_pkg::TICK_W-1:0];
                end
                ura_pkg::REG_GAP: begin
                    gap_reg <= cfg_wdata[ura_pkg::TICK_W-1:0];
                end
                ura_pkg::REG_MAX_DIST: begin
                    max_dist_reg <= cfg_wdata[ura_pkg::DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        width_next     = width_reg;
        round_next     = round_reg;
        sum_next       = sum_reg;
        valid_cnt_next = valid_cnt_reg;
        cm_next        = cm_reg;
        res_trig_next  = res_trig_reg;
        res_done_next  = res_done_reg;
        res_dist_next  = res_dist_reg;
        res_none_next  = res_none_reg;
        m_valid_next   = m_valid_reg;
        m_trig_next    = m_trig_reg;
        m_busy_next    = m_busy_reg;
        m_done_next    = m_done_reg;
        m_dist_next    = m_dist_reg;
        m_none_next    = m_none_reg;
        div_start      = 1'b0;
        round_end      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IN: begin
                if (accept) begin
                    st_next       = ST_OUT;
                    res_trig_next = 1'b0;
                    res_done_next = 1'b0;
                    res_dist_next = '0;
                    res_none_next = 1'b0;
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (s_start_req) begin
                                round_next     = '0;
                                sum_next       = '0;
                                valid_cnt_next = '0;
                                width_next     = '0;
                                tick_next      = '0;
                                phase_next     = PH_PRE_LOW;
                            end
                        end
                        PH_PRE_LOW: begin
                            tick_next = tick_inc;
                            if (tick_inc >= ura_pkg::PRE_LOW_TICKS) begin
                                phase_next = PH_HIGH;
                                tick_next  = '0;
                            end
                        end
                        PH_HIGH: begin
                            res_trig_next = 1'b1;
                            tick_next     = tick_inc;
                            if (tick_inc >= ura_pkg::HIGH_TICKS) begin
                                phase_next = PH_WAIT_RISE;
                                tick_next  = '0;
                            end
                        end
                        PH_WAIT_RISE: begin
                            if (s_echo_level) begin
                                // a zero timeout fails right at the rise
                                if (timeout_reg == '0) begin
                                    round_end = 1'b1;
                                end else begin
                                    width_next = ura_pkg::tick_t'(1);
                                    phase_next = PH_MEASURE;
                                end
                            end else if (tick_reg >= timeout_reg) begin
                                round_end = 1'b1;
                            end else begin
                                tick_next = tick_inc;
                            end
                        end
                        PH_MEASURE: begin
                            if (s_echo_level) begin
                                if (width_reg >= timeout_reg) begin
                                    round_end = 1'b1;
                                end else begin
                                    width_next = width_reg + 1'b1;
                                end
                            end else begin
                                st_next = ST_MUL;
                            end
                        end
                        PH_GAP: begin
                            tick_next = tick_inc;
                            if (tick_inc >= gap_reg) begin
                                st_next = ST_FIN;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                cm_next = cm_prod[ura_pkg::CM_SHIFT +: ura_pkg::RAW_DIST_W];
                st_next = ST_DDIST;
            end
            ST_DDIST: begin
                if (cm_reg < {1'b0, max_dist_reg}) begin
                    sum_next       = sum_reg + ura_pkg::sum_t'(cm_reg);
                    valid_cnt_next = valid_cnt_reg + 1'b1;
                end
                round_end = 1'b1;
            end
            ST_FIN: begin
                round_next = round_inc;
                tick_next  = '0;
                // a wrapped round count also ends the measurement
                if (round_inc == '0 || round_inc >= sample_count_reg) begin
                    phase_next    = PH_IDLE;
                    res_done_next = 1'b1;
                    if (valid_cnt_reg == '0) begin
                        res_none_next = 1'b1;
                        res_dist_next = '0;
                        st_next       = ST_OUT;
                    end else begin
                        div_start = 1'b1;
                        st_next   = ST_DAVG;
                    end
                end else begin
                    phase_next = PH_PRE_LOW;
                    st_next    = ST_OUT;
                end
            end
            ST_DAVG: begin
                if (div_done) begin
                    res_dist_next = div_quot[ura_pkg::DIST_W-1:0];
                    st_next       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_trig_next  = res_trig_reg;
                    m_busy_next  = (phase_reg != PH_IDLE);
                    m_done_next  = res_done_reg;
                    m_dist_next  = res_dist_reg;
                    m_none_next  = res_none_reg;
                    st_next      = ST_IN;
                end
            end
            default: begin
                st_next = ST_IN;
            end
        endcase

        // round over: gap next, or straight to bookkeeping when gap is zero
        if (round_end) begin
            if (gap_reg == '0) begin
                st_next = ST_FIN;
            end else begin
                phase_next = PH_GAP;
                tick_next  = '0;
                st_next    = ST_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IN;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            width_reg     <= '0;
            round_reg     <= '0;
            sum_reg       <= '0;
            valid_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            width_reg     <= width_next;
            round_reg     <= round_next;
            sum_reg       <= sum_next;
            valid_cnt_reg <= valid_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
        cm_reg       <= cm_next;
        res_trig_reg <= res_trig_next;
        res_done_reg <= res_done_next;
        res_dist_reg <= res_dist_next;
        res_none_reg <= res_none_next;
        m_trig_reg   <= m_trig_next;
        m_busy_reg   <= m_busy_next;
        m_done_reg   <= m_done_next;
        m_dist_reg   <= m_dist_next;
        m_none_reg   <= m_none_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_trigger_level = m_trig_reg;
    assign m_busy_res      = m_busy_reg;
    assign m_done_res      = m_done_reg;
    assign m_range_cm      = m_dist_reg;
    assign m_no_valid      = m_none_reg;

    // divider results arrive only while the sequencer waits for the mean
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (st_reg == ST_DAVG))
        else $error("divider result with no consumer");

    // an accepted tick always leaves the input state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (st_reg != ST_IN))
        else $error("tick accepted but not processed");

    // a finished measurement leaves the block idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done beat while still busy");

    // no_valid only with done and a zero distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_valid) |-> (m_done_res && m_range_cm == '0))
        else $error("no_valid beat inconsistent");

endmodule
